// ===== hw/rtl/pbd_pkg.sv =====
// Shared types, constants and register codes of the push button dimmer.
package pbd_pkg;

  // Channel count and timer width.
  localparam int CHANNELS   = 5;
  localparam int MAX_CH     = 5;
  localparam int TIMER_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [7:0]            LEVEL_MAX = 8'd255;

  // Opcodes of an input beat.
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_HOST_OFF = 3'd1;
  localparam logic [2:0] OP_HOST_ON  = 3'd2;
  localparam logic [2:0] OP_HOST_SET = 3'd3;
  localparam logic [2:0] OP_REPORT   = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEVEL_STEP     = 2'd0;
  localparam logic [1:0] REG_SHORT_PRESS    = 2'd1;
  localparam logic [1:0] REG_DIM_INTERVAL   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0]       LEVEL_STEP_RST   = 8'd1;
  localparam logic [CFG_W-1:0] SHORT_PRESS_RST  = 16'd200;
  localparam logic [CFG_W-1:0] DIM_INTERVAL_RST = 16'd10;

  typedef struct packed {
    logic [2:0] opcode;
    logic [4:0] buttons;
    logic [2:0] channel;
    logic [7:0] level_value;
  } pbd_in_t;

  typedef struct packed {
    logic [7:0] drive_0;
    logic [7:0] drive_1;
    logic [7:0] drive_2;
    logic [7:0] drive_3;
    logic [7:0] drive_4;
    logic [4:0] on_mask;
    logic       report;
  } pbd_out_t;

  typedef struct packed {
    logic [7:0]       level_step;
    logic [CFG_W-1:0] short_press_ticks;
    logic [CFG_W-1:0] dim_interval_ticks;
  } pbd_cfg_t;

  // Per-channel command decoded from one input beat.
  typedef struct packed {
    logic       tick;
    logic       pressed;
    logic       host_off;
    logic       host_on;
    logic       host_set;
    logic [7:0] level_value;
  } pbd_cmd_t;

  // Per-channel status after the beat has been applied.
  typedef struct packed {
    logic       light_on;
    logic [7:0] drive;
    logic       report;
  } pbd_stat_t;

endpackage

// ===== hw/rtl/pbd_cfg.sv =====
// Configuration registers of the push button dimmer.
module pbd_cfg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [pbd_pkg::CFG_W-1:0] cfg_wdata,
  output pbd_pkg::pbd_cfg_t       cfg
);
  import pbd_pkg::*;

  pbd_cfg_t cfg_r;
  pbd_cfg_t cfg_nxt;

  // Decode the write; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_LEVEL_STEP:   cfg_nxt.level_step         = cfg_wdata[7:0];
        REG_SHORT_PRESS:  cfg_nxt.short_press_ticks  = cfg_wdata;
        REG_DIM_INTERVAL: cfg_nxt.dim_interval_ticks = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_step         <= LEVEL_STEP_RST;
      cfg_r.short_press_ticks  <= SHORT_PRESS_RST;
      cfg_r.dim_interval_ticks <= DIM_INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/pbd_channel.sv =====
// State and next-state logic of one dimmer channel.
module pbd_channel (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  pbd_pkg::pbd_cmd_t  cmd,
  input  pbd_pkg::pbd_cfg_t  cfg,
  output pbd_pkg::pbd_stat_t stat
);
  import pbd_pkg::*;

  logic [7:0]            level_r, level_nxt;
  logic                  on_r, on_nxt;
  logic                  up_r, up_nxt;
  logic                  held_r, held_nxt;
  logic                  ign_r, ign_nxt;
  logic [TIMER_BITS-1:0] press_r, press_nxt;
  logic [TIMER_BITS-1:0] step_r, step_nxt;
  logic                  rep;

  logic [TIMER_BITS-1:0] press_inc;
  logic [TIMER_BITS-1:0] step_inc;
  logic [8:0]            sum_up;
  logic [7:0]            dimmed;

  // Saturating timer increments.
  assign press_inc = (press_r == TIMER_MAX) ? TIMER_MAX : press_r + 1'b1;
  assign step_inc  = (step_r == TIMER_MAX) ? TIMER_MAX : step_r + 1'b1;
  assign sum_up    = {1'b0, level_r} + {1'b0, cfg.level_step};

  always_comb begin
    level_nxt = level_r;
    on_nxt    = on_r;
    up_nxt    = up_r;
    held_nxt  = held_r;
    ign_nxt   = ign_r;
    press_nxt = press_r;
    step_nxt  = step_r;
    rep       = 1'b0;
    dimmed    = level_r;
    if (cmd.tick) begin
      if (cmd.pressed) begin
        // Restart timers on a fresh press, otherwise count up.
        if (!held_r) begin
          held_nxt  = 1'b1;
          press_nxt = '0;
          step_nxt  = '0;
          ign_nxt   = 1'b0;
        end else begin
          press_nxt = press_inc;
          step_nxt  = step_inc;
        end
        // Switch on a dark light, direction up.
        if (!on_r) begin
          on_nxt  = 1'b1;
          up_nxt  = 1'b1;
          ign_nxt = 1'b1;
        end
        // Step the level once the interval has elapsed.
        if (CMP_W'(step_nxt) >= CMP_W'(cfg.dim_interval_ticks)) begin
          if (up_nxt) begin
            dimmed = sum_up[8] ? LEVEL_MAX : sum_up[7:0];
          end else begin
            dimmed = (level_r > cfg.level_step) ? level_r - cfg.level_step : 8'd0;
          end
          level_nxt = dimmed;
          step_nxt  = '0;
        end
      end else if (held_r) begin
        // Release: a short press that did not switch on turns off; direction flips, report.
        held_nxt = 1'b0;
        if ((CMP_W'(press_inc) <= CMP_W'(cfg.short_press_ticks)) && !ign_r) begin
          on_nxt = 1'b0;
        end
        up_nxt = !up_r;
        rep    = 1'b1;
      end
    end else begin
      // Host commands for this channel.
      if (cmd.host_off) begin
        on_nxt = 1'b0;
      end
      if (cmd.host_on) begin
        on_nxt = 1'b1;
        up_nxt = 1'b1;
      end
      if (cmd.host_set) begin
        level_nxt = cmd.level_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      on_r    <= 1'b0;
      up_r    <= 1'b0;
      held_r  <= 1'b0;
      ign_r   <= 1'b0;
      press_r <= '0;
      step_r  <= '0;
    end else if (en) begin
      level_r <= level_nxt;
      on_r    <= on_nxt;
      up_r    <= up_nxt;
      held_r  <= held_nxt;
      ign_r   <= ign_nxt;
      press_r <= press_nxt;
      step_r  <= step_nxt;
    end
  end

  // Status as it stands after this beat.
  assign stat.light_on = on_nxt;
  assign stat.drive    = on_nxt ? level_nxt : 8'd0;
  assign stat.report   = rep;

endmodule

// ===== hw/rtl/push_button_dimmer_channels.sv =====
// Top level of the five-channel push button dimmer.
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/ready   | opcode, buttons, channel, level_value
//   out_    | output    | out_valid/ready  | drive_0..drive_4, on_mask, report
//   cfg_    | input     | cfg_we           | cfg_index, cfg_wdata
//
// A beat sits in the input register while the channel logic works on it, and its
// result is then registered in the output register; one beat per cycle is
// sustained while the output is not stalled.
// Synchronous active-low reset clears all channel state and both valid flags.
// A stalled output holds the input register; the input side keeps taking beats
// while the input register is empty or the output register is free or being emptied.
module push_button_dimmer_channels (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pbd_pkg::pbd_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output pbd_pkg::pbd_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [pbd_pkg::CFG_W-1:0] cfg_wdata
);
  import pbd_pkg::*;

  pbd_cfg_t  cfg;
  pbd_in_t   s1_r;
  logic      s1_v_r, s1_v_nxt;
  pbd_out_t  out_r, out_nxt;
  logic      out_v_r, out_v_nxt;
  logic      out_free;
  logic      s1_adv;
  logic      host_hit;
  logic [MAX_CH-1:0] ch_on;
  logic [MAX_CH-1:0] ch_rep;
  logic [7:0]        ch_drive [MAX_CH];

  pbd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Handshake: advance the input register when the output can take a beat.
  assign out_free = !out_v_r || out_ready;
  assign s1_adv   = s1_v_r && out_free;
  assign in_ready = !s1_v_r || out_free;

  assign s1_v_nxt  = (in_valid && in_ready) ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  // Host beats count only for an in-range channel and a known opcode.
  assign host_hit = (s1_r.opcode != OP_TICK) && (s1_r.opcode <= OP_REPORT)
                    && (s1_r.channel < 3'(CHANNELS));

  // Channel instances; unused slots read as dark.
  for (genvar c = 0; c < MAX_CH; c++) begin : g_ch
    if (c < CHANNELS) begin : g_live
      pbd_cmd_t  cmd;
      pbd_stat_t stat;
      logic      sel;

      assign sel             = host_hit && (s1_r.channel == 3'(c));
      assign cmd.tick        = (s1_r.opcode == OP_TICK);
      assign cmd.pressed     = s1_r.buttons[c];
      assign cmd.host_off    = sel && (s1_r.opcode == OP_HOST_OFF);
      assign cmd.host_on     = sel && (s1_r.opcode == OP_HOST_ON);
      assign cmd.host_set    = sel && (s1_r.opcode == OP_HOST_SET);
      assign cmd.level_value = s1_r.level_value;

      pbd_channel u_channel (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (s1_adv),
        .cmd   (cmd),
        .cfg   (cfg),
        .stat  (stat)
      );

      assign ch_on[c]    = stat.light_on;
      assign ch_drive[c] = stat.drive;
      assign ch_rep[c]   = stat.report;
    end else begin : g_off
      assign ch_on[c]    = 1'b0;
      assign ch_drive[c] = 8'd0;
      assign ch_rep[c]   = 1'b0;
    end
  end

  // Assemble the result beat.
  always_comb begin
    out_nxt.drive_0 = ch_drive[0];
    out_nxt.drive_1 = ch_drive[1];
    out_nxt.drive_2 = ch_drive[2];
    out_nxt.drive_3 = ch_drive[3];
    out_nxt.drive_4 = ch_drive[4];
    out_nxt.on_mask = ch_on;
    out_nxt.report  = ((s1_r.opcode == OP_TICK) && (|ch_rep)) || host_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_free) |=> s1_v_r)
    else $error("input register dropped a beat while the output stalled");

  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && out_v_r))
    else $error("input ready low with room in the pipeline");

  a_bad_op_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_r.opcode > OP_REPORT)) |=> !out_r.report)
    else $error("report raised for an unused opcode");

  a_drive_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_r.drive_0 == 8'd0) || out_r.on_mask[0]))
    else $error("drive on a channel that is off");
`endif

endmodule
